// ===== hw/rtl/scb_rd_pkg.sv =====
`timescale 1ns / 1ps

package scb_rd_pkg;

    typedef enum logic [1:0] {
        PH_CTRL = 2'd0,
        PH_DUP  = 2'd1,
        PH_COPY = 2'd2,
        PH_SKIP = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        KIND_DATA     = 3'd0,
        KIND_DONE     = 3'd1,
        KIND_ABORT    = 3'd2,
        KIND_OVERFLOW = 3'd3,
        KIND_NO_END   = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_RUN  = 2'd1,
        S_STAT = 2'd2
    } t_ctrl_state;

    typedef struct packed {
        logic load;
        logic push_data;
        logic push_stat;
    } t_cmd;

    typedef struct packed {
        logic slot_free;
        logic run_zero;
        logic run_one;
        logic has_stat;
    } t_sts;

    localparam logic [3:0] NIB_END     = 4'h0;
    localparam logic [3:0] NIB_ABORT   = 4'h4;
    localparam logic [3:0] NIB_BLANK_A = 4'h8;
    localparam logic [3:0] NIB_BLANK_B = 4'h9;
    localparam logic [3:0] NIB_REP_A   = 4'hA;
    localparam logic [3:0] NIB_REP_B   = 4'hB;
    localparam logic [3:0] NIB_LIT_A   = 4'hC;
    localparam logic [3:0] NIB_LIT_B   = 4'hD;
    localparam logic [3:0] NIB_LIT_C   = 4'hE;
    localparam logic [3:0] NIB_LIT_D   = 4'hF;

    localparam logic [7:0]  EBCDIC_BLANK  = 8'h40;
    localparam logic [16:0] LEN_MAX       = 17'h1FFFF;
    localparam logic [15:0] CONS_MAX      = 16'hFFFF;
    localparam logic [15:0] OUT_LIMIT_RST = 16'd256;

    localparam logic REG_OUT_LIMIT = 1'b0;

endpackage

// ===== hw/rtl/scb_record_decompressor_top.sv =====
`timescale 1ns / 1ps

// SCB record decompressor.
// Input channel (i_in_valid/o_in_ready) takes one compressed byte per transfer,
// with i_in_last marking the last byte available. Output channel
// (o_out_valid/i_out_ready) gives one result per transfer: a decoded byte
// (kind 0) or a record status (kinds 1 to 4); o_run_end marks the last result
// of an input byte. The out_limit register sits at APB address 0.
// One byte is worked on at a time: it is taken and decoded, then its results
// are given one by one, a status result after any decoded bytes, and only then
// is the next byte taken. The pace is set by the single output register, which
// takes one result per cycle when it is empty or the receiver takes its result.
// The last result of a byte sits in the output register while the next byte is
// taken. When the receiver stalls, the output register holds and the run
// counter waits. Reset clears the record state, drops any held result and sets
// out_limit to 256.
module scb_record_decompressor_top
    import scb_rd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic [2:0]  o_kind,
    output logic        o_run_end,
    output logic [15:0] o_rec_length,
    output logic [15:0] o_consumed
);

    logic [15:0] r_out_limit;
    t_cmd        w_cmd;
    t_sts        w_sts;
    t_kind       w_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_limit <= OUT_LIMIT_RST;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_OUT_LIMIT)) begin
            r_out_limit <= pwdata[15:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_OUT_LIMIT) ? {16'd0, r_out_limit} : 32'd0;

    scb_rd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    scb_rd_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_out_limit  (r_out_limit),
        .i_in_byte    (i_in_byte),
        .i_in_last    (i_in_last),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_out_byte   (o_out_byte),
        .o_kind       (w_kind),
        .o_run_end    (o_run_end),
        .o_rec_length (o_rec_length),
        .o_consumed   (o_consumed)
    );

    assign o_kind = w_kind;

endmodule

// ===== hw/rtl/scb_rd_ctrl.sv =====
`timescale 1ns / 1ps

module scb_rd_ctrl
    import scb_rd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                if (i_sts.run_zero) begin
                    n_state = i_sts.has_stat ? S_STAT : S_IDLE;
                end else if (i_sts.slot_free) begin
                    o_cmd.push_data = 1'b1;
                    if (i_sts.run_one) begin
                        n_state = i_sts.has_stat ? S_STAT : S_IDLE;
                    end
                end
            end
            S_STAT: begin
                if (i_sts.slot_free) begin
                    o_cmd.push_stat = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/scb_rd_datapath.sv =====
`timescale 1ns / 1ps

module scb_rd_datapath
    import scb_rd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [15:0] i_out_limit,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [7:0]  o_out_byte,
    output t_kind       o_kind,
    output logic        o_run_end,
    output logic [15:0] o_rec_length,
    output logic [15:0] o_consumed
);

    t_phase      r_phase;
    t_phase      n_phase;
    logic [5:0]  r_copy_left;
    logic [5:0]  n_copy_left;
    logic [4:0]  r_dup_count;
    logic [4:0]  n_dup_count;
    logic        r_ovf;
    logic        n_ovf;
    logic [16:0] r_len;
    logic [16:0] n_len;
    logic [15:0] r_cons;
    logic [15:0] n_cons;

    logic [4:0]  r_run_cnt;
    logic [4:0]  n_run_cnt;
    logic [7:0]  r_run_byte;
    logic [7:0]  n_run_byte;
    logic        r_has_stat;
    logic        n_has_stat;
    t_kind       r_stat_kind;
    t_kind       n_stat_kind;
    logic [15:0] r_stat_len;
    logic [15:0] n_stat_len;
    logic [15:0] r_stat_cons;
    logic [15:0] n_stat_cons;

    logic        r_out_valid;
    logic        n_out_valid;
    logic [7:0]  r_out_byte;
    logic [7:0]  n_out_byte;
    t_kind       r_out_kind;
    t_kind       n_out_kind;
    logic        r_out_run_end;
    logic        n_out_run_end;
    logic [15:0] r_out_len;
    logic [15:0] n_out_len;
    logic [15:0] r_out_cons;
    logic [15:0] n_out_cons;

    logic [3:0]  w_hi;
    logic [5:0]  w_cnt;
    logic [17:0] w_sum;
    logic [16:0] w_len_sat;
    logic        w_drop;
    logic [15:0] w_cons_inc;
    logic [5:0]  w_copy_dec;
    logic        w_closed;

    assign w_hi       = i_in_byte[7:4];
    assign w_cnt      = (w_hi >= NIB_LIT_A) ? i_in_byte[5:0] : {1'b0, i_in_byte[4:0]};
    assign w_sum      = {1'b0, r_len} + {12'd0, w_cnt};
    assign w_len_sat  = (w_sum > {1'b0, LEN_MAX}) ? LEN_MAX : w_sum[16:0];
    assign w_drop     = w_len_sat > {1'b0, i_out_limit};
    assign w_cons_inc = (r_cons == CONS_MAX) ? r_cons : r_cons + 16'd1;
    assign w_copy_dec = r_copy_left - 6'd1;

    always_comb begin
        n_phase     = r_phase;
        n_copy_left = r_copy_left;
        n_dup_count = r_dup_count;
        n_ovf       = r_ovf;
        n_len       = r_len;
        n_cons      = r_cons;
        n_run_cnt   = r_run_cnt;
        n_run_byte  = r_run_byte;
        n_has_stat  = r_has_stat;
        n_stat_kind = r_stat_kind;
        n_stat_len  = r_stat_len;
        n_stat_cons = r_stat_cons;
        w_closed    = 1'b0;

        if (i_cmd.load) begin
            n_cons      = w_cons_inc;
            n_run_cnt   = 5'd0;
            n_run_byte  = i_in_byte;
            n_has_stat  = 1'b0;
            n_stat_cons = w_cons_inc;
            n_stat_len  = 16'd0;
            unique case (r_phase)
                PH_CTRL: begin
                    unique case (w_hi) inside
                        NIB_END: begin
                            w_closed    = 1'b1;
                            n_has_stat  = 1'b1;
                            n_stat_kind = r_ovf ? KIND_OVERFLOW : KIND_DONE;
                            n_stat_len  = r_ovf ? 16'd0 : r_len[15:0];
                        end
                        NIB_ABORT: begin
                            w_closed    = 1'b1;
                            n_has_stat  = 1'b1;
                            n_stat_kind = KIND_ABORT;
                        end
                        NIB_BLANK_A, NIB_BLANK_B: begin
                            n_len      = w_len_sat;
                            n_ovf      = r_ovf | w_drop;
                            n_run_byte = EBCDIC_BLANK;
                            n_run_cnt  = w_drop ? 5'd0 : w_cnt[4:0];
                        end
                        NIB_REP_A, NIB_REP_B: begin
                            n_len       = w_len_sat;
                            n_ovf       = r_ovf | w_drop;
                            n_dup_count = w_drop ? 5'd0 : w_cnt[4:0];
                            n_phase     = PH_DUP;
                        end
                        NIB_LIT_A, NIB_LIT_B, NIB_LIT_C, NIB_LIT_D: begin
                            n_len = w_len_sat;
                            n_ovf = r_ovf | w_drop;
                            if (w_cnt != 6'd0) begin
                                n_copy_left = w_cnt;
                                n_phase     = w_drop ? PH_SKIP : PH_COPY;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                PH_DUP: begin
                    n_run_cnt   = r_dup_count;
                    n_dup_count = 5'd0;
                    n_phase     = PH_CTRL;
                end
                PH_COPY: begin
                    n_run_cnt   = 5'd1;
                    n_copy_left = w_copy_dec;
                    if (w_copy_dec == 6'd0) begin
                        n_phase = PH_CTRL;
                    end
                end
                PH_SKIP: begin
                    n_copy_left = w_copy_dec;
                    if (w_copy_dec == 6'd0) begin
                        n_phase = PH_CTRL;
                    end
                end
                default: begin
                end
            endcase

            if (i_in_last && !w_closed) begin
                w_closed    = 1'b1;
                n_has_stat  = 1'b1;
                n_stat_kind = KIND_NO_END;
                n_stat_len  = 16'd0;
            end

            if (w_closed) begin
                n_phase     = PH_CTRL;
                n_copy_left = 6'd0;
                n_dup_count = 5'd0;
                n_ovf       = 1'b0;
                n_len       = 17'd0;
                n_cons      = 16'd0;
            end
        end

        if (i_cmd.push_data) begin
            n_run_cnt = r_run_cnt - 5'd1;
        end
        if (i_cmd.push_stat) begin
            n_has_stat = 1'b0;
        end
    end

    always_comb begin
        n_out_valid   = r_out_valid;
        n_out_byte    = r_out_byte;
        n_out_kind    = r_out_kind;
        n_out_run_end = r_out_run_end;
        n_out_len     = r_out_len;
        n_out_cons    = r_out_cons;
        if (i_cmd.push_data) begin
            n_out_valid   = 1'b1;
            n_out_byte    = r_run_byte;
            n_out_kind    = KIND_DATA;
            n_out_run_end = (r_run_cnt == 5'd1) && !r_has_stat;
            n_out_len     = 16'd0;
            n_out_cons    = 16'd0;
        end else if (i_cmd.push_stat) begin
            n_out_valid   = 1'b1;
            n_out_byte    = 8'd0;
            n_out_kind    = r_stat_kind;
            n_out_run_end = 1'b1;
            n_out_len     = r_stat_len;
            n_out_cons    = r_stat_cons;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_CTRL;
            r_copy_left <= 6'd0;
            r_dup_count <= 5'd0;
            r_ovf       <= 1'b0;
            r_len       <= 17'd0;
            r_cons      <= 16'd0;
            r_run_cnt   <= 5'd0;
            r_has_stat  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_copy_left <= n_copy_left;
            r_dup_count <= n_dup_count;
            r_ovf       <= n_ovf;
            r_len       <= n_len;
            r_cons      <= n_cons;
            r_run_cnt   <= n_run_cnt;
            r_has_stat  <= n_has_stat;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_run_byte    <= n_run_byte;
        r_stat_kind   <= n_stat_kind;
        r_stat_len    <= n_stat_len;
        r_stat_cons   <= n_stat_cons;
        r_out_byte    <= n_out_byte;
        r_out_kind    <= n_out_kind;
        r_out_run_end <= n_out_run_end;
        r_out_len     <= n_out_len;
        r_out_cons    <= n_out_cons;
    end

    assign o_sts.slot_free = !r_out_valid || i_out_ready;
    assign o_sts.run_zero  = (r_run_cnt == 5'd0);
    assign o_sts.run_one   = (r_run_cnt == 5'd1);
    assign o_sts.has_stat  = r_has_stat;

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_kind       = r_out_kind;
    assign o_run_end    = r_out_run_end;
    assign o_rec_length = r_out_len;
    assign o_consumed   = r_out_cons;

endmodule

// ===== hw/rtl/scb_rd_checker.sv =====
`timescale 1ns / 1ps

module scb_rd_checker
    import scb_rd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  o_out_byte,
    input logic [2:0]  o_kind,
    input logic        o_run_end,
    input logic [15:0] o_rec_length,
    input logic [15:0] o_consumed
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_byte) && $stable(o_kind))
        else $error("output result changed before transfer");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_data_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_DATA) |-> (o_rec_length == 16'd0) && (o_consumed == 16'd0))
        else $error("data result carries status fields");

    a_status_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind != KIND_DATA) |-> o_run_end && (o_out_byte == 8'd0))
        else $error("status result not last of its byte");

endmodule

bind scb_record_decompressor_top scb_rd_checker u_scb_rd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_out_byte   (o_out_byte),
    .o_kind       (o_kind),
    .o_run_end    (o_run_end),
    .o_rec_length (o_rec_length),
    .o_consumed   (o_consumed)
);

// ===== dv/tb_scb_record_decompressor_top.sv =====
`timescale 1ns / 1ps

module tb_scb_record_decompressor_top;
    import scb_rd_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int SETTLE_TICKS = 8;
    localparam int LONG_HOLD    = 80;
    localparam int PHASE_BYTES  = 16;
    localparam int N_DIR        = 29;

    typedef enum logic {
        ROW_ITEM  = 1'b0,
        ROW_LIMIT = 1'b1
    } t_row_op;

    typedef struct packed {
        logic [7:0]  data;
        t_kind       kind;
        logic        run_end;
        logic [15:0] len;
        logic [15:0] cons;
    } t_result;

    typedef struct packed {
        t_row_op     op;
        logic [15:0] val;
        logic        last;
        logic        typed;
        t_kind       kind;
        logic [15:0] len;
        logic [15:0] cons;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_in_byte;
    logic        i_in_last;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_out_byte;
    logic [2:0]  o_kind;
    logic        o_run_end;
    logic [15:0] o_rec_length;
    logic [15:0] o_consumed;

    t_result     decoded_q[$];
    t_result     step_q[$];
    t_result     head_res;

    t_phase      rec_phase;
    logic [5:0]  lit_left;
    logic [4:0]  rep_left;
    logic        ovf_seen;
    logic [16:0] dec_len;
    logic [15:0] byte_count;
    logic [15:0] limit_q;

    int unsigned err_count;
    int unsigned bytes_sent;
    int unsigned results_seen;
    int unsigned kind_seen [0:4];
    int unsigned idle_cycles;
    int unsigned tx_gap_pct;
    int unsigned rx_stall_pct;
    int unsigned hold_req;
    int unsigned hold_seen;
    int unsigned hold_left;

    t_dir_row dir_rows [0:N_DIR-1] = '{
        '{ROW_ITEM,  16'h0000, 1'b0, 1'b1, KIND_DONE,     16'd0,  16'd1},
        '{ROW_ITEM,  16'h004F, 1'b0, 1'b1, KIND_ABORT,    16'd0,  16'd1},
        '{ROW_ITEM,  16'h009F, 1'b0, 1'b0, KIND_DATA,     16'd0,  16'd0},
        '{ROW_ITEM,  16'h00BF, 1'b0, 1'b0, KIND_DATA,     16'd0,  16'd0},
        '{ROW_ITEM,  16'h00FF, 1'b0, 1'b0, KIND_DATA,     16'd0,  16'd0},
        '{ROW_ITEM,  16'h00C3, 1'b0, 1'b0, KIND_DATA,     16'd0,  16'd0},
        '{ROW_ITEM,  16'h0000, 1'b0, 1'b0, KIND_DATA,     16'd0,  16'd0},
        '{ROW_ITEM,  16'h00FF, 1'b0, 1'b0, KIND_DATA,     16'd0,  16'd0},
        '{ROW_ITEM,  16'h004A, 1'b0, 1'b0, KIND_DATA,     16'd0,  16'd0},
        '{ROW_ITEM,  16'h0080, 1'b0, 1'b0, KIND_DATA,     16'd0,  16'd0},
        '{ROW_ITEM,  16'h00A0, 1'b0, 1'b0, KIND_DATA,     16'd0,  16'd0},
        '{ROW_ITEM,  16'h0055, 1'b0, 1'b0, KIND_DATA,     16'd0,  16'd0},
        '{ROW_ITEM,  16'h00C0, 1'b0, 1'b0, KIND_DATA,     16'd0,  16'd0},
        '{ROW_ITEM,  16'h0035, 1'b0, 1'b0, KIND_DATA,     16'd0,  16'd0},
        '{ROW_ITEM,  16'h000F, 1'b0, 1'b1, KIND_DONE,     16'd65, 16'd13},
        '{ROW_ITEM,  16'h00C1, 1'b1, 1'b1, KIND_NO_END,   16'd0,  16'd1},
        '{ROW_ITEM,  16'h0000, 1'b1, 1'b1, KIND_DONE,     16'd0,  16'd1},
        '{ROW_ITEM,  16'h0045, 1'b1, 1'b1, KIND_ABORT,    16'd0,  16'd1},
        '{ROW_ITEM,  16'h0083, 1'b1, 1'b0, KIND_DATA,     16'd0,  16'd0},
        '{ROW_LIMIT, 16'h0000, 1'b0, 1'b0, KIND_DATA,     16'd0,  16'd0},
        '{ROW_ITEM,  16'h0081, 1'b0, 1'b0, KIND_DATA,     16'd0,  16'd0},
        '{ROW_ITEM,  16'h00A2, 1'b0, 1'b0, KIND_DATA,     16'd0,  16'd0},
        '{ROW_ITEM,  16'h0077, 1'b0, 1'b0, KIND_DATA,     16'd0,  16'd0},
        '{ROW_ITEM,  16'h00C2, 1'b0, 1'b0, KIND_DATA,     16'd0,  16'd0},
        '{ROW_ITEM,  16'h0011, 1'b0, 1'b0, KIND_DATA,     16'd0,  16'd0},
        '{ROW_ITEM,  16'h0022, 1'b0, 1'b0, KIND_DATA,     16'd0,  16'd0},
        '{ROW_ITEM,  16'h0000, 1'b0, 1'b1, KIND_OVERFLOW, 16'd0,  16'd7},
        '{ROW_ITEM,  16'h0085, 1'b1, 1'b1, KIND_NO_END,   16'd0,  16'd1},
        '{ROW_LIMIT, 16'hFFFF, 1'b0, 1'b0, KIND_DATA,     16'd0,  16'd0}
    };

    scb_record_decompressor_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_byte    (i_in_byte),
        .i_in_last    (i_in_last),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_kind       (o_kind),
        .o_run_end    (o_run_end),
        .o_rec_length (o_rec_length),
        .o_consumed   (o_consumed)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic log_mismatch(input string what, input int unsigned got,
                                input int unsigned want);
        if (err_count < 30) begin
            $display("MISMATCH %s: got 0x%0h, want 0x%0h (result %0d)", what, got, want,
                     results_seen);
        end
        err_count++;
    endtask

    function automatic void start_record();
        rec_phase  = PH_CTRL;
        lit_left   = '0;
        rep_left   = '0;
        ovf_seen   = 1'b0;
        dec_len    = '0;
        byte_count = '0;
    endfunction

    function automatic void queue_step(input logic [7:0] d, input t_kind k,
                                       input logic [15:0] len, input logic [15:0] cons);
        step_q.push_back(t_result'{d, k, 1'b0, len, cons});
    endfunction

    function automatic logic grow_len(input logic [5:0] cnt);
        logic [17:0] total;
        total   = {1'b0, dec_len} + 18'(cnt);
        dec_len = (total > {1'b0, LEN_MAX}) ? LEN_MAX : total[16:0];
        if (dec_len > {1'b0, limit_q}) begin
            ovf_seen = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic last);
        logic    drop;
        logic    closed;
        t_result tail;
        step_q.delete();
        closed = 1'b0;
        if (byte_count != CONS_MAX) byte_count++;
        case (rec_phase)
            PH_CTRL: begin
                if (b[7:4] == NIB_END) begin
                    if (ovf_seen) queue_step(8'h00, KIND_OVERFLOW, 16'd0, byte_count);
                    else queue_step(8'h00, KIND_DONE, dec_len[15:0], byte_count);
                    start_record();
                    closed = 1'b1;
                end else if (b[7:4] == NIB_ABORT) begin
                    queue_step(8'h00, KIND_ABORT, 16'd0, byte_count);
                    start_record();
                    closed = 1'b1;
                end else if (b[7:4] == NIB_BLANK_A || b[7:4] == NIB_BLANK_B) begin
                    drop = grow_len({1'b0, b[4:0]});
                    if (!drop) begin
                        repeat (b[4:0]) queue_step(EBCDIC_BLANK, KIND_DATA, 16'd0, 16'd0);
                    end
                end else if (b[7:4] == NIB_REP_A || b[7:4] == NIB_REP_B) begin
                    drop      = grow_len({1'b0, b[4:0]});
                    rep_left  = drop ? 5'd0 : b[4:0];
                    rec_phase = PH_DUP;
                end else if (b[7:4] >= NIB_LIT_A) begin
                    drop = grow_len(b[5:0]);
                    if (b[5:0] != 6'd0) begin
                        lit_left  = b[5:0];
                        rec_phase = drop ? PH_SKIP : PH_COPY;
                    end
                end
            end
            PH_DUP: begin
                repeat (rep_left) queue_step(b, KIND_DATA, 16'd0, 16'd0);
                rep_left  = '0;
                rec_phase = PH_CTRL;
            end
            PH_COPY: begin
                queue_step(b, KIND_DATA, 16'd0, 16'd0);
                lit_left--;
                if (lit_left == 6'd0) rec_phase = PH_CTRL;
            end
            default: begin
                lit_left--;
                if (lit_left == 6'd0) rec_phase = PH_CTRL;
            end
        endcase
        if (last && !closed) begin
            queue_step(8'h00, KIND_NO_END, 16'd0, byte_count);
            start_record();
        end
        if (step_q.size() != 0) begin
            tail = step_q.pop_back();
            tail.run_end = 1'b1;
            step_q.push_back(tail);
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                             input t_result typed_res);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_gap_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_byte  = b;
        i_in_last  = last;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
        decode_byte(b, last);
        if (typed) begin
            decoded_q.push_back(typed_res);
        end else begin
            foreach (step_q[k]) decoded_q.push_back(step_q[k]);
        end
    endtask

    task automatic send_plain(input logic [7:0] b);
        send_byte(b, $urandom_range(0, 29) == 0, 1'b0, '0);
    endtask

    function automatic int unsigned run_len(input int unsigned max_len);
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return 0;
        if (r == 1) return max_len;
        return $urandom_range(1, 8);
    endfunction

    task automatic send_record();
        int unsigned sel;
        int unsigned cnt;
        int unsigned nib;
        int unsigned r;
        repeat ($urandom_range(1, 5)) begin
            sel = $urandom_range(0, 9);
            if (sel < 3) begin
                cnt = run_len(31);
                send_plain({3'b100, cnt[4:0]});
            end else if (sel < 6) begin
                cnt = run_len(31);
                send_plain({3'b101, cnt[4:0]});
                send_plain(8'($urandom_range(0, 255)));
            end else if (sel < 9) begin
                cnt = run_len(63);
                send_plain({2'b11, cnt[5:0]});
                repeat (cnt) send_plain(8'($urandom_range(0, 255)));
            end else begin
                nib = $urandom_range(1, 6);
                if (nib >= 4) nib++;
                send_plain({nib[3:0], 4'($urandom_range(0, 15))});
            end
        end
        r = $urandom_range(0, 9);
        if (r < 7) begin
            send_byte({NIB_END, 4'($urandom_range(0, 15))}, $urandom_range(0, 2) == 0,
                      1'b0, '0);
        end else if (r == 7) begin
            send_byte({NIB_ABORT, 4'($urandom_range(0, 15))}, 1'b0, 1'b0, '0);
        end else begin
            send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [15:0] v);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {REG_OUT_LIMIT, 2'b00};
        pwdata  = {16'h0000, v};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        limit_q = v;
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[15:0] != v) log_mismatch("out_limit readback", prdata[15:0], v);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
        end
        if (hold_left != 0) begin
            i_out_ready = 1'b0;
            hold_left--;
        end else begin
            i_out_ready = ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (decoded_q.size() == 0) begin
                log_mismatch("transfer with nothing pending, kind", o_kind, 0);
            end else begin
                head_res = decoded_q.pop_front();
                kind_seen[head_res.kind]++;
                if (o_out_byte != head_res.data)
                    log_mismatch("out_byte", o_out_byte, head_res.data);
                if (o_kind != head_res.kind) log_mismatch("kind", o_kind, head_res.kind);
                if (o_run_end != head_res.run_end)
                    log_mismatch("run_end", o_run_end, head_res.run_end);
                if (o_rec_length != head_res.len)
                    log_mismatch("rec_length", o_rec_length, head_res.len);
                if (o_consumed != head_res.cons)
                    log_mismatch("consumed", o_consumed, head_res.cons);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results pending",
                     idle_cycles, decoded_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        i_in_valid   = 1'b0;
        i_in_byte    = '0;
        i_in_last    = 1'b0;
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        hold_req     = 0;
        hold_seen    = 0;
        hold_left    = 0;
        err_count    = 0;
        bytes_sent   = 0;
        results_seen = 0;
        idle_cycles  = 0;
        foreach (kind_seen[k]) kind_seen[k] = 0;
        limit_q = OUT_LIMIT_RST;
        start_record();

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[k]) begin
            if (dir_rows[k].op == ROW_LIMIT) begin
                wait_drained();
                write_limit(dir_rows[k].val);
            end else begin
                send_byte(dir_rows[k].val[7:0], dir_rows[k].last, dir_rows[k].typed,
                          t_result'{8'h00, dir_rows[k].kind, 1'b1, dir_rows[k].len,
                                    dir_rows[k].cons});
            end
        end

        for (int ph = 0; ph < 4; ph++) begin
            int unsigned first_byte;
            wait_drained();
            case (ph)
                0: begin
                    tx_gap_pct   = 0;
                    rx_stall_pct = 0;
                    write_limit(16'd300);
                    hold_req++;
                end
                1: begin
                    tx_gap_pct   = 52;
                    rx_stall_pct = 0;
                    write_limit(16'd40);
                end
                2: begin
                    tx_gap_pct   = 0;
                    rx_stall_pct = 52;
                    write_limit(16'($urandom_range(8, 100)));
                end
                default: begin
                    tx_gap_pct   = 8;
                    rx_stall_pct = 8;
                    write_limit(16'd16);
                end
            endcase
            first_byte = bytes_sent;
            while (bytes_sent < first_byte + PHASE_BYTES) send_record();
        end

        wait_drained();
        repeat (40) @(posedge i_clk);

        $display("Sent %0d compressed bytes, checked %0d results: %0d data, %0d done, %0d abort,",
                 bytes_sent, results_seen, kind_seen[KIND_DATA], kind_seen[KIND_DONE],
                 kind_seen[KIND_ABORT]);
        $display("%0d overflow, %0d missing end; limits 0 to 65535, four flow-control phases.",
                 kind_seen[KIND_OVERFLOW], kind_seen[KIND_NO_END]);
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/scb_rd_pkg.sv
hw/rtl/scb_rd_ctrl.sv
hw/rtl/scb_rd_datapath.sv
hw/rtl/scb_record_decompressor_top.sv
hw/rtl/scb_rd_checker.sv
dv/tb_scb_record_decompressor_top.sv
